@@ hdl/skxsc_pkg.sv @@
// Shared types and fixed tables for the serial-keyed XOR byte scrambler.
// No dependencies; imported by skxsc_keystream and the top level.
package skxsc_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [4:0]  pos_t;
    typedef logic [5:0]  bit_idx_t;
    typedef logic [63:0] serial_t;

    localparam int unsigned CODE_LEN = 32;

    localparam bit_idx_t SERIAL_PICK [0:CODE_LEN-1] = '{
        6'd1,  6'd7,  6'd2,  6'd4,  6'd11, 6'd14, 6'd11, 6'd8,
        6'd19, 6'd18, 6'd21, 6'd23, 6'd24, 6'd28, 6'd27, 6'd31,
        6'd34, 6'd33, 6'd37, 6'd35, 6'd42, 6'd46, 6'd40, 6'd41,
        6'd55, 6'd50, 6'd49, 6'd52, 6'd59, 6'd58, 6'd62, 6'd61
    };

    localparam byte_t CODE_ZERO [0:CODE_LEN-1] = '{
        8'h12, 8'h34, 8'h56, 8'h33, 8'h4e, 8'hf3, 8'h21, 8'hac,
        8'h45, 8'hdc, 8'h1a, 8'h32, 8'h36, 8'h0f, 8'h12, 8'h42,
        8'h54, 8'hd3, 8'haf, 8'h23, 8'h69, 8'hdf, 8'hbc, 8'h31,
        8'h86, 8'hcd, 8'hb4, 8'hbe, 8'h8c, 8'h94, 8'h73, 8'h29
    };

    localparam byte_t CODE_ONE [0:CODE_LEN-1] = '{
        8'h21, 8'hfd, 8'h36, 8'h11, 8'hdc, 8'hbb, 8'h37, 8'hbf,
        8'haa, 8'h56, 8'h29, 8'h70, 8'h66, 8'h2c, 8'h78, 8'h69,
        8'hda, 8'hc2, 8'hc7, 8'hb8, 8'h6d, 8'h4a, 8'h3b, 8'hc6,
        8'hca, 8'had, 8'hb9, 8'ha0, 8'hc5, 8'h2d, 8'h8b, 8'hf2
    };

endpackage

@@ hdl/serial_keyed_xor_stream_cipher.sv @@
// Top level of the serial-keyed XOR byte scrambler.
// Depends on skxsc_pkg and skxsc_keystream.
//
// Usage:
//   Config channel (cfg_valid/cfg_ready/cfg_data) loads the 64-bit device
//   serial; cfg_ready is always high. Write it only while the stream is idle.
//   Input channel (in_valid/in_ready) carries one byte per beat with
//   end_of_message marking the last byte of a buffer. Output channel
//   (out_valid/out_ready) returns the scrambled byte and end_flag.
//   A byte accepted on the input is shown on the output from the next
//   cycle. Throughput is one byte per cycle while the receiver keeps up,
//   set by the single result register; the position counter advances once
//   per accepted beat. When the receiver stalls, the result register holds
//   and in_ready drops only while that register is full and not being taken.
//   Reset clears the serial to zero, the position to zero and the output
//   valid flag. The position returns to zero after a byte marked last and
//   wraps after position 31. The same operation encrypts and decrypts.
module serial_keyed_xor_stream_cipher
    import skxsc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,

    input  logic    cfg_valid,
    output logic    cfg_ready,
    input  serial_t cfg_data,

    input  logic    in_valid,
    output logic    in_ready,
    input  byte_t   in_byte,
    input  logic    end_of_message,

    output logic    out_valid,
    input  logic    out_ready,
    output byte_t   out_byte,
    output logic    end_flag
);

    serial_t serial_reg;
    pos_t    pos_reg;
    pos_t    pos_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    byte_t   out_byte_reg;
    logic    end_flag_reg;
    byte_t   key_byte;
    logic    in_accept;

    skxsc_keystream u_keystream
    (
        .pos      (pos_reg),
        .serial   (serial_reg),
        .key_byte (key_byte)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        pos_next       = end_of_message ? '0 : pos_reg + 5'd1;
        out_valid_next = in_accept ? 1'b1 : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            serial_reg    <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                serial_reg <= cfg_data;
            end
            if (in_accept)
            begin
                pos_reg <= pos_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_byte_reg <= in_byte ^ key_byte;
            end_flag_reg <= end_of_message;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign end_flag  = end_flag_reg;

    a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && end_of_message |=> pos_reg == '0)
        else $error("position not restarted after last byte");

    a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !end_of_message |=> pos_reg == $past(pos_reg) + 5'd1)
        else $error("position did not advance");

    a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> $stable(pos_reg))
        else $error("position moved without an input beat");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid && end_flag == $past(end_of_message))
        else $error("result missing after input beat");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");

endmodule

@@ hdl/skxsc_keystream.sv @@
// Key byte for one stream position: picks a serial bit and selects a code table.
// Depends on skxsc_pkg for the pick table and both code tables.
module skxsc_keystream
    import skxsc_pkg::*;
(
    input  pos_t    pos,
    input  serial_t serial,
    output byte_t   key_byte
);

    bit_idx_t pick;
    logic     use_one;

    always_comb
    begin
        pick     = SERIAL_PICK[pos];
        use_one  = serial[pick];
        key_byte = use_one ? CODE_ONE[pos] : CODE_ZERO[pos];
    end

endmodule
